// ===== src/wnm_pkg.sv =====
// ----------------------------------------------------------------------------
// wnm_pkg
// shared constants and types for the wildcard name match unit
// ----------------------------------------------------------------------------
package wnm_pkg;

  localparam int PATTERN_CHARS = 56;
  localparam int POSITIONS     = PATTERN_CHARS + 1;
  localparam int POS_W         = $clog2(POSITIONS);
  localparam int WORD_BYTES    = 8;
  localparam int WORD_COUNT    = PATTERN_CHARS / WORD_BYTES;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = $clog2(WORD_COUNT + 1);
  localparam int LEN_W         = 6;

  localparam logic [7:0] QMARK_BYTE = 8'h3F;
  localparam logic [7:0] STAR_BYTE  = 8'h2A;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = CFG_IDX_W'(1);

  // reset values
  localparam logic [LEN_W-1:0]      RESET_LENGTH = LEN_W'(1);
  localparam logic [CFG_DATA_W-1:0] RESET_WORD_0 = CFG_DATA_W'(42);

  // broadcast to every cell
  typedef struct packed {
    logic step;   // advance on an accepted byte that does not end the name
    logic load;   // reload the start set
  } cell_ctrl_t;

  // what one cell hands to the row
  typedef struct packed {
    logic stay;   // star keeps this position live
    logic adv;    // position moves on to the neighbor
    logic star;   // active position holding a star
  } cell_flags_t;

endpackage

// ===== src/wnm_in_if.sv =====
// ----------------------------------------------------------------------------
// wnm_in_if
// name byte channel
// ----------------------------------------------------------------------------
interface wnm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       name_last;

  modport source (output valid, output name_byte, output name_last, input ready);
  modport sink (input valid, input name_byte, input name_last, output ready);
endinterface

// ===== src/wnm_out_if.sv =====
// ----------------------------------------------------------------------------
// wnm_out_if
// match result channel
// ----------------------------------------------------------------------------
interface wnm_out_if;
  logic valid;
  logic ready;
  logic is_match;

  modport source (output valid, output is_match, input ready);
  modport sink (input valid, input is_match, output ready);
endinterface

// ===== src/wnm_cell.sv =====
// ----------------------------------------------------------------------------
// wnm_cell
// one pattern position: holds its live bit and passes advances to its neighbor
// ----------------------------------------------------------------------------
module wnm_cell (
  input  logic               clk,
  input  wnm_pkg::cell_ctrl_t ctrl,
  input  logic               active,
  input  logic [7:0]         pat_byte,
  input  logic [7:0]         name_byte,
  input  logic               fill,
  input  logic               start,
  output wnm_pkg::cell_flags_t flags
);

  logic live;
  logic on;
  logic is_star;

  assign on      = live & active;
  assign is_star = (pat_byte == wnm_pkg::STAR_BYTE);

  always_comb begin
    flags.star = active & is_star;
    flags.stay = on & is_star;
    flags.adv  = on & ~is_star &
                 ((pat_byte == wnm_pkg::QMARK_BYTE) | (pat_byte == name_byte));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      live <= start;
    end else if (ctrl.step) begin
      live <= fill;
    end
  end

endmodule

// ===== src/wnm_star_fill.sv =====
// ----------------------------------------------------------------------------
// wnm_star_fill
// closes a position set over runs of stars with one carry chain
// ----------------------------------------------------------------------------
module wnm_star_fill (
  input  logic [wnm_pkg::POSITIONS-1:0] seed,
  input  logic [wnm_pkg::POSITIONS-1:0] star,
  output logic [wnm_pkg::POSITIONS-1:0] fill
);

  logic [wnm_pkg::POSITIONS-1:0] sum;
  logic [wnm_pkg::POSITIONS-1:0] gen;
  logic [wnm_pkg::POSITIONS-1:0] carry;

  // a live star generates a carry, a star propagates it; the carry into a
  // position marks it reached through a run of stars
  // the final position never holds a star, so no carry leaves the top
  assign gen   = seed & star;
  assign sum   = star + gen;
  assign carry = sum ^ star ^ gen;
  assign fill  = seed | carry;

endmodule

// ===== src/wildcard_name_match_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_name_match_unit
// matches streamed entry names against a '?' / '*' wildcard pattern
// ----------------------------------------------------------------------------
//
//   channel     dir   handshake     payload
//   name_in     in    valid/ready   name_byte[7:0], name_last
//   result_out  out   valid/ready   is_match
//   cfg         in    cfg_we        cfg_index[2:0], cfg_data[63:0]
//
// one name byte per cycle while name_in is ready; the row of position cells
// and the star carry chain update the whole position set at once per byte
// the result of a name is shown the cycle after its last byte is taken
// after reset and after each register write the start set loads, and name_in
// is not ready while it does; otherwise name_in stalls only while a result
// waits and result_out is not ready
//
module wildcard_name_match_unit (
  input  logic                             clk,
  input  logic                             rst,
  wnm_in_if.sink                           name_in,
  wnm_out_if.source                        result_out,
  input  logic                             cfg_we,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wnm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NP = wnm_pkg::POSITIONS;

  // configuration
  logic [wnm_pkg::LEN_W-1:0]      pattern_length;
  logic [wnm_pkg::CFG_DATA_W-1:0] pattern_words [wnm_pkg::WORD_COUNT];
  logic [wnm_pkg::CFG_IDX_W-1:0]  word_sel;

  // control
  logic                      restart;   // start set must be loaded
  logic                      accept;
  logic [wnm_pkg::POS_W-1:0] len_used;
  wnm_pkg::cell_ctrl_t       ctrl;

  // position row
  wnm_pkg::cell_flags_t flags [NP];
  logic [NP-1:0] stay;
  logic [NP-1:0] adv;
  logic [NP-1:0] star;
  logic [NP-1:0] pre;
  logic [NP-1:0] filled;
  logic [NP-1:0] start_set;

  // output stage
  logic out_valid;
  logic out_match;

  // lengths above the pattern capacity are clamped
  assign len_used = (pattern_length > wnm_pkg::LEN_W'(wnm_pkg::PATTERN_CHARS)) ?
                    wnm_pkg::POS_W'(wnm_pkg::PATTERN_CHARS) :
                    wnm_pkg::POS_W'(pattern_length);

  assign word_sel = cfg_index - wnm_pkg::REG_PATTERN_WORD_0;

  // config writes; every write restarts the name
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= wnm_pkg::RESET_LENGTH;
      pattern_words[0] <= wnm_pkg::RESET_WORD_0;
      for (int k = 1; k < wnm_pkg::WORD_COUNT; k++) begin
        pattern_words[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == wnm_pkg::REG_PATTERN_LENGTH) begin
        pattern_length <= cfg_data[wnm_pkg::LEN_W-1:0];
      end else begin
        pattern_words[word_sel] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
    end else begin
      restart <= cfg_we;
    end
  end

  // input stalls during a restart or while the result slot stays full
  assign name_in.ready = ~restart & (~out_valid | result_out.ready);
  assign accept        = name_in.valid & name_in.ready;

  // a last byte reloads the start set at once, like a restart
  assign ctrl.step = accept & ~name_in.name_last;
  assign ctrl.load = restart | (accept & name_in.name_last);

  // the row of cells, one per pattern position plus the final position
  for (genvar i = 0; i < NP; i++) begin : g_cell
    logic [7:0] pat_byte;
    logic       active;

    if (i < wnm_pkg::PATTERN_CHARS) begin : g_byte
      assign pat_byte = pattern_words[i / wnm_pkg::WORD_BYTES]
                                     [(i % wnm_pkg::WORD_BYTES) * 8 +: 8];
    end else begin : g_end
      // final position holds no pattern byte
      assign pat_byte = 8'h00;
    end

    assign active = (wnm_pkg::POS_W'(i) < len_used);

    wnm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .active    (active),
      .pat_byte  (pat_byte),
      .name_byte (name_in.name_byte),
      .fill      (filled[i]),
      .start     (start_set[i]),
      .flags     (flags[i])
    );

    assign stay[i] = flags[i].stay;
    assign adv[i]  = flags[i].adv;
    assign star[i] = flags[i].star;
  end

  // a position stays on a star or is reached from its left neighbor
  assign pre = stay | {adv[NP-2:0], 1'b0};

  // close the stepped set over star runs
  wnm_star_fill u_step_fill (
    .seed (pre),
    .star (star),
    .fill (filled)
  );

  // start set: position zero plus leading stars
  wnm_star_fill u_start_fill (
    .seed (NP'(1)),
    .star (star),
    .fill (start_set)
  );

  // result register parts the two channels
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept & name_in.name_last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept & name_in.name_last) begin
      out_match <= filled[len_used];
    end
  end

  assign result_out.valid    = out_valid;
  assign result_out.is_match = out_match;

endmodule

// ===== src/wnm_checker.sv =====
// ----------------------------------------------------------------------------
// wnm_checker
// port-level checks for the wildcard name match unit
// ----------------------------------------------------------------------------
module wnm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_match,
  input logic cfg_we
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_match))
    else $error("result dropped or changed while stalled");

  // every last byte taken gives a result the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no result after last byte");

  // a fresh result only follows a taken last byte
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !($past(out_valid) && !$past(out_ready))
      |-> $past(in_valid && in_ready && in_last))
    else $error("result without a last byte");

  // start set reload blocks input right after a register write
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input taken during restart");

endmodule

bind wildcard_name_match_unit wnm_checker u_wnm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (name_in.valid),
  .in_ready  (name_in.ready),
  .in_last   (name_in.name_last),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_match (result_out.is_match),
  .cfg_we    (cfg_we)
);

// ===== test/wildcard_name_match_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_name_match_unit_test
// streams entry names through the wildcard matcher and checks every verdict
// against a cycle-free model of the live pattern position set, across
// directed corner cases and randomized patterns, names, idling and back-pressure
// ----------------------------------------------------------------------------
module wildcard_name_match_unit_test;

  localparam int LONG_HOLD   = 300;   // receiver hold-off for the fill-up phase
  localparam int QUIET_LIMIT = 2000;  // cycles without any handshake before giving up
  localparam int ROUNDS      = 16;    // random pattern settings
  localparam int ROUND_ITEMS = 22;    // minimum name bytes per pattern setting
  localparam int SETTLE      = 4;     // cycles after the last verdict before a write
  localparam int TAIL        = 10;    // cycles after the last verdict at the end

  // keeps its own copy of the pattern and the position set, queues verdicts
  class match_tracker;
    logic [wnm_pkg::LEN_W-1:0]      len_reg;
    logic [wnm_pkg::CFG_DATA_W-1:0] word_reg[wnm_pkg::WORD_COUNT];
    logic [wnm_pkg::POSITIONS-1:0]  live;
    logic                           verdict_q[$];
    int                             errors;

    function new();
      len_reg = wnm_pkg::RESET_LENGTH;
      foreach (word_reg[k]) word_reg[k] = '0;
      word_reg[0] = wnm_pkg::RESET_WORD_0;
      errors = 0;
      live = start_set();
    endfunction

    // lengths above the pattern store are clamped
    function int active_len();
      return (int'(len_reg) > wnm_pkg::PATTERN_CHARS) ? wnm_pkg::PATTERN_CHARS :
             int'(len_reg);
    endfunction

    function logic [7:0] char_at(int pos);
      return word_reg[pos / wnm_pkg::WORD_BYTES][(pos % wnm_pkg::WORD_BYTES) * 8 +: 8];
    endfunction

    // a live star also makes the next position live, chained upward
    function logic [wnm_pkg::POSITIONS-1:0] close_stars(logic [wnm_pkg::POSITIONS-1:0] s);
      int n;
      n = active_len();
      for (int i = 0; i < n; i++)
        if (s[i] && char_at(i) == wnm_pkg::STAR_BYTE) s[i + 1] = 1'b1;
      return s;
    endfunction

    function logic [wnm_pkg::POSITIONS-1:0] start_set();
      return close_stars(wnm_pkg::POSITIONS'(1));
    endfunction

    // any register write restarts the current name
    function void write_reg(logic [wnm_pkg::CFG_IDX_W-1:0] idx,
                            logic [wnm_pkg::CFG_DATA_W-1:0] data);
      if (idx == wnm_pkg::REG_PATTERN_LENGTH) len_reg = data[wnm_pkg::LEN_W-1:0];
      else word_reg[int'(idx) - int'(wnm_pkg::REG_PATTERN_WORD_0)] = data;
      live = start_set();
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [wnm_pkg::POSITIONS-1:0] nxt;
      int n;
      logic [7:0] p;
      n = active_len();
      nxt = '0;
      for (int i = 0; i < n; i++) begin
        if (live[i]) begin
          p = char_at(i);
          if (p == wnm_pkg::STAR_BYTE) nxt[i] = 1'b1;
          else if (p == wnm_pkg::QMARK_BYTE || p == b) nxt[i + 1] = 1'b1;
        end
      end
      nxt = close_stars(nxt);
      if (last) begin
        verdict_q.push_back(nxt[n]);
        live = start_set();
      end else begin
        live = nxt;
      end
    endfunction

    function void take_result(logic actual);
      logic want;
      if (verdict_q.size() == 0) begin
        $error("is_match: no verdict pending, actual %0b", actual);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (want !== actual) begin
          $error("is_match mismatch: expected %0b, actual %0b", want, actual);
          errors++;
        end
      end
    endfunction

    function int waiting();
      return verdict_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [wnm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wnm_pkg::CFG_DATA_W-1:0] cfg_data;

  wnm_in_if  name_in();
  wnm_out_if result_out();

  wildcard_name_match_unit uut (
    .clk        (clk),
    .rst        (rst),
    .name_in    (name_in),
    .result_out (result_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  match_tracker tracker;

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // long hold-off request: main flips it, the receiver counts the hold itself
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  int quiet_cycles = 0;

  // pattern as programmed, and the name being built
  logic [7:0] pat_chars[wnm_pkg::PATTERN_CHARS];
  int         pat_used;
  logic [7:0] name_q[$];

  always #2 clk = ~clk;

  // every handshake and register write is noted at the edge it happens on;
  // verdicts are checked before the byte of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (result_out.valid && result_out.ready) tracker.take_result(result_out.is_match);
      if (name_in.valid && name_in.ready) tracker.take_byte(name_in.name_byte, name_in.name_last);
      if (cfg_we) tracker.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver: random stalls, or a long hold when asked for
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst) begin
      if ((name_in.valid && name_in.ready) || (result_out.valid && result_out.ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // offer one byte after a random gap, return on the edge it is taken;
  // valid stays high so back-to-back bytes stream without a bubble
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      name_in.valid <= 1'b0;
      @(posedge clk);
    end
    name_in.valid     <= 1'b1;
    name_in.name_byte <= b;
    name_in.name_last <= last;
    @(posedge clk);
    while (!name_in.ready) @(posedge clk);
  endtask

  task automatic send_name();
    foreach (name_q[i]) send_byte(name_q[i], i == name_q.size() - 1);
  endtask

  // leaves the write enable high so writes can run back to back
  task automatic set_reg(input logic [wnm_pkg::CFG_IDX_W-1:0] idx,
                         input logic [wnm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // wait for every verdict, then for the block to go quiet
  task automatic settle();
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // length in the low bits, random junk above
  function automatic logic [wnm_pkg::CFG_DATA_W-1:0] len_word(int n);
    logic [wnm_pkg::CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    w[wnm_pkg::LEN_W-1:0] = wnm_pkg::LEN_W'(n);
    return w;
  endfunction

  // write all registers, starting at a random index
  task automatic load_pattern(input logic [wnm_pkg::CFG_DATA_W-1:0] lw);
    int first;
    logic [wnm_pkg::CFG_IDX_W-1:0] idx;
    logic [wnm_pkg::CFG_DATA_W-1:0] w;
    first = $urandom_range(0, wnm_pkg::WORD_COUNT);
    for (int k = 0; k <= wnm_pkg::WORD_COUNT; k++) begin
      idx = wnm_pkg::CFG_IDX_W'((first + k) % (wnm_pkg::WORD_COUNT + 1));
      if (idx == wnm_pkg::REG_PATTERN_LENGTH) begin
        w = lw;
      end else begin
        for (int j = 0; j < wnm_pkg::WORD_BYTES; j++)
          w[j * 8 +: 8] = pat_chars[(int'(idx) - int'(wnm_pkg::REG_PATTERN_WORD_0)) *
                                    wnm_pkg::WORD_BYTES + j];
      end
      set_reg(idx, w);
    end
    cfg_we <= 1'b0;
  endtask

  // small alphabet so literals line up, with wildcards and raw bytes mixed in
  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 15) return wnm_pkg::STAR_BYTE;
    if (r < 35) return wnm_pkg::QMARK_BYTE;
    if (r < 85) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 8'h61 + 8'($urandom_range(0, 2));
    if (r < 70) return wnm_pkg::STAR_BYTE;
    if (r < 75) return wnm_pkg::QMARK_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly names built to fit the pattern, some of them damaged by one
  // byte, the rest noise; never empty
  task automatic make_name();
    int r;
    int pos;
    name_q.delete();
    r = $urandom_range(99);
    if (r < 70) begin
      for (int i = 0; i < pat_used; i++) begin
        if (pat_chars[i] == wnm_pkg::STAR_BYTE) begin
          repeat ($urandom_range(0, 3)) name_q.push_back(name_char());
        end else if (pat_chars[i] == wnm_pkg::QMARK_BYTE) begin
          name_q.push_back(name_char());
        end else begin
          name_q.push_back(pat_chars[i]);
        end
      end
      if (r < 25 && name_q.size() > 0) begin
        pos = $urandom_range(0, name_q.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            name_q[pos] = name_char();
          end
          1: begin
            name_q.delete(pos);
          end
          default: begin
            name_q.insert(pos, name_char());
          end
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8))
        name_q.push_back((r < 85) ? name_char() : 8'($urandom_range(0, 255)));
    end
    if (name_q.size() == 0) name_q.push_back(name_char());
  endtask

  initial begin
    int n;
    int items;
    int mode;

    tracker = new();
    name_in.valid     <= 1'b0;
    name_in.name_byte <= '0;
    name_in.name_last <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    rst               <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part, no idling ----

    // reset pattern is a lone star: a zero byte, the top byte, a star in the name
    name_q = '{8'h00};
    send_name();
    name_q = '{8'hFF, wnm_pkg::STAR_BYTE};
    send_name();
    name_in.valid <= 1'b0;
    settle();

    // "a?*", a zero byte, "z"
    foreach (pat_chars[i]) pat_chars[i] = 8'h00;
    pat_chars[0] = 8'h61;
    pat_chars[1] = wnm_pkg::QMARK_BYTE;
    pat_chars[2] = wnm_pkg::STAR_BYTE;
    pat_chars[3] = 8'h00;
    pat_chars[4] = 8'h7A;
    pat_used = 5;
    load_pattern(len_word(5));
    name_q = '{8'h61, wnm_pkg::QMARK_BYTE, 8'h00, 8'h7A};
    send_name();
    // stars in the name are eaten by the wildcard star
    name_q = '{8'h61, wnm_pkg::STAR_BYTE, wnm_pkg::STAR_BYTE, wnm_pkg::STAR_BYTE,
               8'h00, 8'h7A};
    send_name();
    name_q = '{8'h61, 8'h62, 8'h7A};
    send_name();
    name_q = '{8'h61, 8'h00};
    send_name();

    // write in the middle of a name, which restarts it; empty pattern never matches
    send_byte(8'h61, 1'b0);
    name_in.valid <= 1'b0;
    settle();
    set_reg(wnm_pkg::REG_PATTERN_LENGTH, len_word(0));
    cfg_we <= 1'b0;
    pat_used = 0;
    name_q = '{wnm_pkg::STAR_BYTE};
    send_name();
    name_in.valid <= 1'b0;
    settle();

    // oversized length clamps to the full store of stars
    foreach (pat_chars[i]) pat_chars[i] = wnm_pkg::STAR_BYTE;
    pat_used = wnm_pkg::PATTERN_CHARS;
    load_pattern(len_word(63));
    name_q = '{8'h7A};
    send_name();

    // ---- random part ----
    for (int r = 0; r < ROUNDS; r++) begin
      name_in.valid <= 1'b0;
      settle();

      // idling phases: none, sender, receiver, both
      mode = r % 4;
      send_idle_pct  = (mode == 1) ? 70 : (mode == 3) ? 22 : 0;
      recv_stall_pct = (mode == 2) ? 70 : (mode == 3) ? 22 : 0;

      // full store, oversized, empty, then mostly short patterns
      case (r)
        0: n = wnm_pkg::PATTERN_CHARS;
        1: n = 63;
        2: n = 0;
        default: begin
          if ($urandom_range(0, 9) == 0) n = $urandom_range(13, wnm_pkg::PATTERN_CHARS);
          else n = $urandom_range(1, 12);
        end
      endcase
      foreach (pat_chars[i])
        pat_chars[i] = (r == 0) ? 8'($urandom_range(0, 255)) : pattern_char();
      pat_used = (n > wnm_pkg::PATTERN_CHARS) ? wnm_pkg::PATTERN_CHARS : n;
      load_pattern(len_word(n));

      // receiver holds off while names keep coming, so the input backs up
      if (r == 4) hold_toggle = ~hold_toggle;

      items = 0;
      while (items < ROUND_ITEMS) begin
        make_name();
        send_name();
        items += name_q.size();
      end
    end
    name_in.valid <= 1'b0;

    // drain and let the pipeline go quiet
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
